>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define PRQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("priority queue check failed");

// same check with its own message
`define PRQ_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

>>> design/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } prq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } prq_status_e;

  typedef struct packed {
    prq_cmd_e   command;
    logic [7:0] proc_id;
    logic [7:0] prio;
  } prq_in_t;

  typedef struct packed {
    prq_status_e status;
    logic [4:0]  entry_count;
    logic        front_valid;
    logic [7:0]  front_id;
    logic [7:0]  front_prio;
  } prq_out_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } prq_slot_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       remove;
    logic [7:0] id;
    logic [7:0] prio;
  } prq_ctrl_t;

endpackage

`default_nettype wire

>>> design/prq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prq_in_if;
  logic             valid;
  logic             ready;
  prq_pkg::prq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prq_out_if;
  logic              valid;
  logic              ready;
  prq_pkg::prq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/prq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module prq_cell (
  input  wire logic               clk_i,
  input  wire prq_pkg::prq_ctrl_t ctrl_i,
  input  wire logic               occ_i,
  input  wire prq_pkg::prq_slot_t left_i,
  input  wire logic               left_keep_i,
  input  wire prq_pkg::prq_slot_t right_i,
  input  wire logic               hit_i,
  output prq_pkg::prq_slot_t      slot_o,
  output logic                    keep_o,
  output logic                    hit_o
);

  prq_pkg::prq_slot_t slot_q, slot_d, new_slot;
  logic               match;

  assign new_slot = '{id: ctrl_i.id, prio: ctrl_i.prio};
  assign match    = occ_i && (slot_q.id == ctrl_i.id);
  // entry stays put on push when it sorts at or ahead of the new one
  assign keep_o   = occ_i && (slot_q.prio <= ctrl_i.prio);
  assign hit_o    = hit_i || match;
  assign slot_o   = slot_q;

  always_comb begin
    slot_d = slot_q;
    priority if (ctrl_i.push) begin
      if (!keep_o) begin
        slot_d = left_keep_i ? new_slot : left_i;
      end
    end else if (ctrl_i.pop) begin
      slot_d = right_i;
    end else if (ctrl_i.remove && hit_o) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

>>> design/priority_ready_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Stable sorted ready queue of DEPTH entries (id, priority), smallest priority at the front and
// equal priorities in arrival order. Each entry sits in one cell of a chain; push, pop and
// remove-by-id update every cell in the cycle the command word is taken, so the block takes one
// command per clock and returns one result word per command in the next cycle, from a single output
// register. Input ready drops only while that result word is held by a stalled sink. The longest
// path is the priority compare in each cell plus the id-match chain that runs through all DEPTH
// cells for a remove.

module priority_ready_queue_top #(
  parameter int unsigned DEPTH = prq_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prq_in_if.sink    in_i,
  prq_out_if.source out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  prq_pkg::prq_slot_t   slot  [DEPTH];
  logic [DEPTH-1:0]     keep;
  logic [DEPTH-1:0]     occ;
  logic [DEPTH:0]       hit;
  prq_pkg::prq_ctrl_t   ctrl;
  prq_pkg::prq_status_e status_q, status_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  logic                 in_ready, accept, full, empty, found, front_valid;

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign found      = hit[DEPTH];
  assign hit[0]     = 1'b0;

  assign ctrl.push   = accept && (in_i.data.command == prq_pkg::CMD_PUSH) && !full;
  assign ctrl.pop    = accept && (in_i.data.command == prq_pkg::CMD_POP) && !empty;
  assign ctrl.remove = accept && (in_i.data.command == prq_pkg::CMD_REMOVE);
  assign ctrl.id     = in_i.data.proc_id;
  assign ctrl.prio   = in_i.data.prio;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    prq_pkg::prq_slot_t left, right;
    logic               left_keep;

    assign occ[k] = (count_q > CW'(k));

    if (k == 0) begin : g_head
      assign left      = slot[k];
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left      = slot[k-1];
      assign left_keep = keep[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right = slot[k];
    end else begin : g_inner
      assign right = slot[k+1];
    end

    prq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[k]),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .hit_i       (hit[k]),
      .slot_o      (slot[k]),
      .keep_o      (keep[k]),
      .hit_o       (hit[k+1])
    );
  end

  always_comb begin
    status_d = prq_pkg::ST_OK;
    count_d  = count_q;
    unique case (in_i.data.command)
      prq_pkg::CMD_PUSH: begin
        if (full) status_d = prq_pkg::ST_FULL;
        else      count_d  = count_q + CW'(1);
      end
      prq_pkg::CMD_POP: begin
        if (empty) status_d = prq_pkg::ST_EMPTY;
        else       count_d  = count_q - CW'(1);
      end
      prq_pkg::CMD_REMOVE: begin
        if (found) count_d  = count_q - CW'(1);
        else       status_d = prq_pkg::ST_NOT_FOUND;
      end
      prq_pkg::CMD_NOP: begin
        status_d = prq_pkg::ST_OK;
      end
      default: begin
        status_d = prq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_ready) begin
        out_valid_q <= in_i.valid;
      end
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  // queue cannot change while a result word waits, so the front is read live
  assign front_valid            = !empty;
  assign out_o.valid            = out_valid_q;
  assign out_o.data.status      = status_q;
  assign out_o.data.entry_count = 5'(count_q);
  assign out_o.data.front_valid = front_valid;
  assign out_o.data.front_id    = front_valid ? slot[0].id : 8'd0;
  assign out_o.data.front_prio  = front_valid ? slot[0].prio : 8'd0;

  `PRQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `PRQ_ASSERT_MSG(a_push_grows, ctrl.push |=> count_q == $past(count_q) + CW'(1), "push lost")
  `PRQ_ASSERT(a_full_status, out_valid_q && status_q == prq_pkg::ST_FULL |-> full)
  `PRQ_ASSERT_MSG(a_front_sorted, count_q >= CW'(2) |-> slot[0].prio <= slot[1].prio, "unsorted")

endmodule

`default_nettype wire
